// File: rtl/core/smms_pkg.sv
// Shared types and codes for the sample mean / extremes / deviation block.
// Used by smms_dp, smms_ctrl and the top module. No dependencies.
`default_nettype none
package smms_pkg;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mean_scaled;
    logic signed [31:0] max_scaled;
    logic signed [31:0] min_scaled;
    logic [30:0]        deviation_scaled;
    logic               saturated;
  } out_item_t;

  // selects what the shared divider works on and where its quotient goes
  typedef logic [2:0] div_src_t;
  localparam div_src_t SRC_MEAN  = 3'd0;
  localparam div_src_t SRC_VAR   = 3'd1;
  localparam div_src_t SRC_SMEAN = 3'd4;
  localparam div_src_t SRC_SMAX  = 3'd5;
  localparam div_src_t SRC_SMIN  = 3'd6;
  localparam div_src_t SRC_SDEV  = 3'd7;

  localparam logic [31:0] SCALE_RESET = 32'd65536;
  localparam logic [31:0] POS_LIMIT   = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT   = 32'h8000_0000;

  typedef struct packed {
    logic     accept;
    logic     clr_set;
    logic     pass_clr;
    logic     div_start;
    logic     div_ld;
    div_src_t div_src;
    logic     rd_issue;
    logic     sq_abs;
    logic     sq_mul;
    logic     sq_acc;
    logic     sqrt_start;
    logic     dev_ld;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic sqrt_done;
    logic pass_last;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/smms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module smms_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/smms_div.sv
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on nothing but its ports.
`default_nettype none
module smms_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output      logic        busy_o,
  output      logic        done_o,
  output      logic [63:0] quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvsr_q, dvsr_d;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, dvd_q[63]};
  assign ge     = rem_sh >= {1'b0, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 32'(rem_sh - {1'b0, dvsr_q}) : rem_sh[31:0];
      dvd_d = {dvd_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

// File: rtl/core/smms_sqrt.sv
// Digit-by-digit floor square root of a 64-bit value, two radicand bits a cycle.
// Depends on nothing but its ports.
`default_nettype none
module smms_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output      logic        done_o,
  output      logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] val_q, val_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  assign rem_sh = {rem_q, val_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? 33'(rem_sh - trial) : rem_sh[32:0];
      root_d = {root_q[30:0], ge};
      val_d  = {val_q[61:0], 2'b00};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// File: rtl/core/smms_dp.sv
// Datapath: sample store, running sum/min/max, square pass, divider, root, scaling.
// Depends on smms_pkg, smms_ram, smms_div and smms_sqrt.
`default_nettype none
module smms_dp #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire smms_pkg::in_item_t  in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire smms_pkg::cmd_t      cmd_i,
  output      smms_pkg::sts_t      sts_o,
  output      smms_pkg::out_item_t out_data_o
);
  import smms_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SUMW = 32 + CW;
  localparam int SQW  = 48 + CW;
  localparam int SH   = 32 - SAMPLE_WIDTH;

  logic [31:0]            scale_q;
  logic [CW-1:0]          count_q;
  logic signed [SUMW-1:0] sum_q;
  logic signed [31:0]     min_q, max_q, mean_q;
  logic [AW-1:0]          idx_q;
  logic [31:0]            abs_q;
  logic [63:0]            prod_q;
  logic [SQW-1:0]         sq_q;
  logic [47:0]            var_q;
  logic [31:0]            dev_q;
  logic                   neg_q, sat_q;
  logic signed [31:0]     res_mean_q, res_max_q, res_min_q, res_dev_q;
  out_item_t              out_q;

  logic signed [31:0] shifted, x;
  logic               room;
  logic [31:0]        rd_data;
  logic signed [32:0] diff;
  logic [SUMW-1:0]    sum_mag;
  logic signed [32:0] src_val;
  logic [32:0]        src_mag;
  logic [63:0]        dividend;
  logic [31:0]        divisor;
  logic [63:0]        quot;
  logic               div_busy, div_done, sqrt_done;
  logic [31:0]        root;
  logic signed [31:0] scaled;
  logic               clip;

  // low SAMPLE_WIDTH bits, sign-extended
  assign shifted = in_data_i.sample <<< SH;
  assign x       = shifted >>> SH;
  assign room    = count_q < CW'(MAX_SAMPLES);

  smms_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES), .ADDR_W(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && room),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (x),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign diff    = 33'($signed(rd_data)) - 33'(mean_q);
  assign sum_mag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

  always_comb begin
    case (cmd_i.div_src)
      SRC_SMAX: src_val = 33'(max_q);
      SRC_SMIN: src_val = 33'(min_q);
      SRC_SDEV: src_val = $signed({1'b0, dev_q});
      default:  src_val = 33'(mean_q);
    endcase
  end
  assign src_mag = src_val[32] ? 33'(-src_val) : 33'(src_val);

  always_comb begin
    case (cmd_i.div_src)
      SRC_MEAN: begin
        dividend = 64'(sum_mag);
        divisor  = 32'(count_q);
      end
      SRC_VAR: begin
        dividend = 64'(sq_q);
        divisor  = 32'(count_q);
      end
      default: begin
        dividend = 64'({src_mag[31:0], 16'h0000});
        divisor  = (scale_q == '0) ? 32'd1 : scale_q;
      end
    endcase
  end

  smms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  smms_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i ({var_q, 16'h0000}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // quotient back to a signed, clipped 32-bit result
  always_comb begin
    scaled = $signed(quot[31:0]);
    clip   = 1'b0;
    if (neg_q) begin
      if (quot > 64'(NEG_LIMIT)) begin
        scaled = $signed(NEG_LIMIT);
        clip   = 1'b1;
      end else begin
        scaled = $signed(32'(-quot[31:0]));
      end
    end else if (quot > 64'(POS_LIMIT)) begin
      scaled = $signed(POS_LIMIT);
      clip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      sq_q    <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_set) begin
        count_q <= '0;
        sum_q   <= '0;
      end else if (cmd_i.accept && room) begin
        count_q <= count_q + CW'(1);
        sum_q   <= sum_q + SUMW'(x);
        if (count_q == '0 || x < min_q) begin
          min_q <= x;
        end
        if (count_q == '0 || x > max_q) begin
          max_q <= x;
        end
      end
      if (cmd_i.pass_clr) begin
        sq_q  <= '0;
        idx_q <= '0;
      end else if (cmd_i.sq_acc) begin
        sq_q  <= sq_q + SQW'(prod_q[63:16]);
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= (cmd_i.div_src == SRC_MEAN) ? sum_q[SUMW-1] : src_val[32];
    end
    if (cmd_i.pass_clr) begin
      sat_q <= 1'b0;
    end else if (cmd_i.div_ld && cmd_i.div_src[2]) begin
      sat_q <= sat_q | clip;
    end
    if (cmd_i.sq_abs) begin
      abs_q <= diff[32] ? 32'(-diff) : diff[31:0];
    end
    if (cmd_i.sq_mul) begin
      prod_q <= 64'(abs_q) * 64'(abs_q);
    end
    if (cmd_i.dev_ld) begin
      dev_q <= root;
    end
    if (cmd_i.div_ld) begin
      case (cmd_i.div_src)
        SRC_MEAN:  mean_q     <= scaled;
        SRC_VAR:   var_q      <= quot[47:0];
        SRC_SMEAN: res_mean_q <= scaled;
        SRC_SMAX:  res_max_q  <= scaled;
        SRC_SMIN:  res_min_q  <= scaled;
        SRC_SDEV:  res_dev_q  <= scaled;
        default:   ;
      endcase
    end
    if (cmd_i.out_ld) begin
      out_q.mean_scaled      <= res_mean_q;
      out_q.max_scaled       <= res_max_q;
      out_q.min_scaled       <= res_min_q;
      out_q.deviation_scaled <= res_dev_q[30:0];
      out_q.saturated        <= sat_q;
    end
  end

  assign sts_o.div_busy  = div_busy;
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.pass_last = (CW'(idx_q) + CW'(1)) == count_q;
  assign out_data_o      = out_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.div_start |-> !div_busy)
    else $error("divider started while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q <= CW'(MAX_SAMPLES))
    else $error("sample count beyond store depth");
  a_pass_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.rd_issue |-> count_q != '0)
    else $error("square pass over an empty set");

endmodule
`default_nettype wire

// File: rtl/core/smms_ctrl.sv
// Controller state machine sequencing load, mean, square pass, variance, root, scaling.
// Depends on smms_pkg.
`default_nettype none
module smms_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_last_i,
  output      logic           in_stall_o,
  output      logic           out_valid_o,
  input  wire logic           out_stall_i,
  input  wire smms_pkg::sts_t sts_i,
  output      smms_pkg::cmd_t cmd_o
);
  import smms_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MDIV  = 4'd1;
  localparam logic [3:0] S_MWAIT = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_VDIV  = 4'd7;
  localparam logic [3:0] S_VWAIT = 4'd8;
  localparam logic [3:0] S_ROOT  = 4'd9;
  localparam logic [3:0] S_RWAIT = 4'd10;
  localparam logic [3:0] S_SDIV  = 4'd11;
  localparam logic [3:0] S_SWAIT = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       oval_q, oval_d;
  logic       accept;

  assign in_stall_o = state_q != S_LOAD;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    oval_d  = oval_q && out_stall_i;
    cmd_o   = '0;
    cmd_o.accept  = accept;
    cmd_o.div_src = SRC_SMEAN + div_src_t'(k_q);
    case (state_q)
      S_LOAD: begin
        if (accept && in_last_i) begin
          state_d = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd_o.div_src   = SRC_MEAN;
        cmd_o.div_start = 1'b1;
        cmd_o.pass_clr  = 1'b1;
        state_d         = S_MWAIT;
      end
      S_MWAIT: begin
        cmd_o.div_src = SRC_MEAN;
        if (sts_i.div_done) begin
          cmd_o.div_ld = 1'b1;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_ABS;
      end
      S_ABS: begin
        cmd_o.sq_abs = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.sq_acc = 1'b1;
        state_d      = sts_i.pass_last ? S_VDIV : S_RD;
      end
      S_VDIV: begin
        cmd_o.div_src   = SRC_VAR;
        cmd_o.div_start = 1'b1;
        state_d         = S_VWAIT;
      end
      S_VWAIT: begin
        cmd_o.div_src = SRC_VAR;
        if (sts_i.div_done) begin
          cmd_o.div_ld = 1'b1;
          state_d      = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_RWAIT;
      end
      S_RWAIT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.dev_ld = 1'b1;
          k_d          = '0;
          state_d      = S_SDIV;
        end
      end
      S_SDIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_ld = 1'b1;
          k_d          = k_q + 2'd1;
          state_d      = (k_q == 2'd3) ? S_EMIT : S_SDIV;
        end
      end
      S_EMIT: begin
        // previous result may still be waiting at the output
        if (!oval_q || !out_stall_i) begin
          cmd_o.out_ld  = 1'b1;
          cmd_o.clr_set = 1'b1;
          oval_d        = 1'b1;
          state_d       = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      k_q     <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o = oval_q;

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.out_ld |-> (!oval_q || !out_stall_i))
    else $error("result register overwritten while held");
  a_ld_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.div_ld |-> sts_i.div_done)
    else $error("quotient taken before divider finished");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      sts_i.div_busy |-> in_stall_o)
    else $error("input open while divider busy");

endmodule
`default_nettype wire

// File: rtl/core/sample_mean_minmax_stddev.sv
// Mean, min, max and population standard deviation of a set of Q16.16 samples.
// Samples load one per cycle. After the last beat of a set, the time to the result
// grows with the sample count and is set by the bit-serial divider (six uses),
// the read/abs/multiply/accumulate pass per sample and the bit-serial root.
// Input is stalled from the last beat until the result is in the output register.
// Reset (rst_ni low, asynchronous) empties the set and sets the scale to 1.0.
`default_nettype none
module sample_mean_minmax_stddev #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire smms_pkg::in_item_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      smms_pkg::out_item_t out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i
);
  import smms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smms_dp #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
